FILE: design/dtrm_pkg.sv
// dtrm_pkg: shared constants, command codes and the command word type
// used between the front classifier, the command queue and the back executor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dtrm_pkg;

  localparam int UPDATE_COLUMNS = 32;
  localparam int UPDATE_ROWS    = 16;
  localparam int TILE_SHIFT     = 4;

  localparam int COORD_W = 16;
  localparam int COL_W   = (UPDATE_COLUMNS > 1) ? $clog2(UPDATE_COLUMNS) : 1;
  localparam int ROW_W   = (UPDATE_ROWS > 1) ? $clog2(UPDATE_ROWS) : 1;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // input operation codes
  localparam logic [1:0] FUNC_MARK  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // command kinds after classification
  localparam logic [1:0] CMD_MARK  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_REPLY = 2'd3;

  typedef struct packed {
    logic [1:0]                kind;
    logic                      accepted;
    logic [UPDATE_COLUMNS-1:0] mask;
    logic [ROW_W-1:0]          y_first;
    logic [ROW_W-1:0]          y_last;
    logic [COL_W-1:0]          q_col;
    logic [ROW_W-1:0]          q_row;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/dtrm_front.sv
// dtrm_front: turns an input word into a command word
// tile conversion, rejection, clipping and column mask; uses dtrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtrm_front (
  input  wire logic [1:0]                func,
  input  wire logic signed [15:0]        left_x,
  input  wire logic signed [15:0]        top_y,
  input  wire logic signed [15:0]        right_x,
  input  wire logic signed [15:0]        bottom_y,
  input  wire logic [4:0]                query_col,
  input  wire logic [3:0]                query_row,
  output dtrm_pkg::cmd_t                 cmd
);
  import dtrm_pkg::*;

  localparam logic signed [COORD_W-1:0] LAST_COL = COORD_W'(UPDATE_COLUMNS - 1);
  localparam logic signed [COORD_W-1:0] NUM_ROWS = COORD_W'(UPDATE_ROWS);
  localparam logic signed [COORD_W-1:0] ZERO_T   = '0;

  logic signed [COORD_W-1:0] xt1, yt1, xt2, yt2;
  logic signed [COORD_W-1:0] xs, xe, ys, ye;
  logic                      reject, empty, q_in_grid;
  logic [UPDATE_COLUMNS-1:0] mask;

  assign xt1 = left_x >>> TILE_SHIFT;
  assign yt1 = top_y >>> TILE_SHIFT;
  assign xt2 = right_x >>> TILE_SHIFT;
  assign yt2 = bottom_y >>> TILE_SHIFT;

  assign reject = (xt1 >= LAST_COL) || (yt1 > NUM_ROWS) || (xt2 < ZERO_T) || (yt2 < ZERO_T);

  assign xs = (xt1 < ZERO_T) ? ZERO_T : xt1;
  assign ys = (yt1 < ZERO_T) ? ZERO_T : yt1;
  assign xe = (xt2 >= LAST_COL) ? LAST_COL - 16'sd1 : xt2;
  assign ye = (yt2 >= NUM_ROWS) ? NUM_ROWS - 16'sd1 : yt2;

  assign empty = (xe < xs) || (ye < ys);

  always_comb begin
    logic signed [COORD_W-1:0] col_v;
    col_v = '0;
    for (int i = 0; i < UPDATE_COLUMNS; i++) begin
      col_v   = COORD_W'(i);
      mask[i] = (col_v >= xs) && (col_v <= xe);
    end
  end

  assign q_in_grid = ({27'd0, query_col} < 32'(UPDATE_COLUMNS)) &&
                     ({28'd0, query_row} < 32'(UPDATE_ROWS));

  always_comb begin
    cmd          = '0;
    cmd.mask     = mask;
    cmd.y_first  = ROW_W'(ys);
    cmd.y_last   = ROW_W'(ye);
    cmd.q_col    = COL_W'(query_col);
    cmd.q_row    = ROW_W'(query_row);
    cmd.accepted = 1'b1;
    cmd.kind     = CMD_REPLY;
    case (func)
      FUNC_MARK: begin
        if (reject) begin
          cmd.accepted = 1'b0;
        end else if (!empty) begin
          cmd.kind = CMD_MARK;
        end
      end
      FUNC_CLEAR: begin
        cmd.kind = CMD_CLEAR;
      end
      FUNC_QUERY: begin
        if (q_in_grid) begin
          cmd.kind = CMD_QUERY;
        end
      end
      default: begin
        cmd.kind = CMD_REPLY;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/dtrm_cmd_fifo.sv
// dtrm_cmd_fifo: short command queue between front and back
// uses dtrm_pkg for the command type and depth
`timescale 1ns / 1ps
`default_nettype none

module dtrm_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire dtrm_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output dtrm_pkg::cmd_t      pop_data,
  output logic                empty
);
  import dtrm_pkg::*;

  cmd_t                  slot_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full     = (count_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/dtrm_back.sv
// dtrm_back: executes commands against the tile map memory and holds the
// result register; row read-modify-write for marks. uses dtrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtrm_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_empty,
  input  wire dtrm_pkg::cmd_t cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                out_accepted,
  output logic                out_tile_dirty
);
  import dtrm_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MARK  = 2'd1;
  localparam logic [1:0] S_QWAIT = 2'd2;

  logic [UPDATE_COLUMNS-1:0] map_mem [UPDATE_ROWS];
  logic [UPDATE_ROWS-1:0]    row_vld_r;
  logic [UPDATE_COLUMNS-1:0] rd_data_r;
  logic                      rd_vld_r;
  logic [UPDATE_COLUMNS-1:0] rd_eff, wr_data;

  logic [1:0]                state_r, state_nxt;
  logic [ROW_W-1:0]          wr_row_r, wr_row_nxt;
  logic [ROW_W-1:0]          ylast_r, ylast_nxt;
  logic [UPDATE_COLUMNS-1:0] mask_r, mask_nxt;
  logic [COL_W-1:0]          qcol_r, qcol_nxt;

  logic                      out_valid_r, out_accepted_r, out_dirty_r;
  logic                      out_free, out_load, load_acc, load_dirty;
  logic                      rd_en, wr_en, clr_all;
  logic [ROW_W-1:0]          rd_addr;

  assign rd_eff   = rd_vld_r ? rd_data_r : '0;
  assign wr_data  = rd_eff | mask_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    wr_row_nxt = wr_row_r;
    ylast_nxt  = ylast_r;
    mask_nxt   = mask_r;
    qcol_nxt   = qcol_r;
    cmd_pop    = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = wr_row_r;
    wr_en      = 1'b0;
    clr_all    = 1'b0;
    out_load   = 1'b0;
    load_acc   = 1'b1;
    load_dirty = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_MARK: begin
              rd_en      = 1'b1;
              rd_addr    = cmd.y_first;
              wr_row_nxt = cmd.y_first;
              ylast_nxt  = cmd.y_last;
              mask_nxt   = cmd.mask;
              state_nxt  = S_MARK;
            end
            CMD_CLEAR: begin
              clr_all  = 1'b1;
              out_load = 1'b1;
            end
            CMD_QUERY: begin
              rd_en     = 1'b1;
              rd_addr   = cmd.q_row;
              qcol_nxt  = cmd.q_col;
              state_nxt = S_QWAIT;
            end
            default: begin
              out_load = 1'b1;
              load_acc = cmd.accepted;
            end
          endcase
        end
      end
      S_MARK: begin
        wr_en = 1'b1;
        if (wr_row_r == ylast_r) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = wr_row_r + 1'b1;
          wr_row_nxt = wr_row_r + 1'b1;
        end
      end
      S_QWAIT: begin
        out_load   = 1'b1;
        load_dirty = rd_eff[qcol_r];
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_all) begin
        row_vld_r <= '0;
      end else if (wr_en) begin
        row_vld_r[wr_row_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // map memory, one row write and one registered row read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_row_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= map_mem[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    wr_row_r <= wr_row_nxt;
    ylast_r  <= ylast_nxt;
    mask_r   <= mask_nxt;
    qcol_r   <= qcol_nxt;
    if (out_load) begin
      out_accepted_r <= load_acc;
      out_dirty_r    <= load_dirty;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_tile_dirty = out_dirty_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded over a pending word");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == S_IDLE) && !cmd_empty)
    else $error("command taken outside idle");

  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |-> (wr_row_r <= ylast_r))
    else $error("mark walked past last row");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_all |=> (row_vld_r == '0))
    else $error("clear left a row marked");

endmodule

`default_nettype wire

FILE: design/dirty_tile_rect_marker_unit.sv
// dirty_tile_rect_marker_unit: top level of the dirty tile marker
// front classifier, command queue and back executor; uses dtrm_pkg
//
// input channel: in_valid / in_stall with func, rectangle corners and query
// tile address. output channel: out_valid / out_stall with accepted and
// tile_dirty, one word out for every word in, in order.
// a mark turns the rectangle into tile rows and a column mask, then writes
// one map row per cycle by read-modify-write. clear-all drops the row valid
// bits at once, a query answers from a registered row read, and rejected
// or empty marks and the unused code answer without touching the map.
// the front and a two-word command queue keep taking words while the back
// works; in_stall rises only when the queue is full.
// the back starts a command only when the result register is free or being
// taken, so a stalled receiver holds the result and backs up the queue.
// reset (rst_n low, synchronous) empties the queue, drops the result and
// marks every tile clear.
`timescale 1ns / 1ps
`default_nettype none

module dirty_tile_rect_marker_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_func,
  input  wire logic signed [15:0] in_left_x,
  input  wire logic signed [15:0] in_top_y,
  input  wire logic signed [15:0] in_right_x,
  input  wire logic signed [15:0] in_bottom_y,
  input  wire logic [4:0]         in_query_col,
  input  wire logic [3:0]         in_query_row,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_accepted,
  output logic                    out_tile_dirty
);
  import dtrm_pkg::*;

  cmd_t front_cmd, q_cmd;
  logic q_full, q_empty, q_pop;

  dtrm_front u_front (
    .func      (in_func),
    .left_x    (in_left_x),
    .top_y     (in_top_y),
    .right_x   (in_right_x),
    .bottom_y  (in_bottom_y),
    .query_col (in_query_col),
    .query_row (in_query_row),
    .cmd       (front_cmd)
  );

  dtrm_cmd_fifo u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_cmd),
    .empty     (q_empty)
  );

  dtrm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_empty      (q_empty),
    .cmd            (q_cmd),
    .cmd_pop        (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_accepted   (out_accepted),
    .out_tile_dirty (out_tile_dirty)
  );

  assign in_stall = q_full;

endmodule

`default_nettype wire

FILE: tb/tb_dirty_tile_rect_marker_unit.sv
// tb_dirty_tile_rect_marker_unit: self-checking bench for the dirty tile marker
// predicts each reply from its own tile map and checks every output word in order
// depends on dtrm_pkg and dirty_tile_rect_marker_unit
`timescale 1ns / 1ps

module tb_dirty_tile_rect_marker_unit;
  import dtrm_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1528;
  localparam int HOLD_CYCLES = 120;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] left_x;
    logic signed [15:0] top_y;
    logic signed [15:0] right_x;
    logic signed [15:0] bottom_y;
    logic [4:0]         query_col;
    logic [3:0]         query_row;
  } tile_word_t;

  typedef struct packed {
    logic accepted;
    logic tile_dirty;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic signed [15:0] in_left_x = '0;
  logic signed [15:0] in_top_y = '0;
  logic signed [15:0] in_right_x = '0;
  logic signed [15:0] in_bottom_y = '0;
  logic [4:0] in_query_col = '0;
  logic [3:0] in_query_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_accepted;
  logic out_tile_dirty;

  dirty_tile_rect_marker_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_left_x(in_left_x),
    .in_top_y(in_top_y),
    .in_right_x(in_right_x),
    .in_bottom_y(in_bottom_y),
    .in_query_col(in_query_col),
    .in_query_row(in_query_row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_accepted(out_accepted),
    .out_tile_dirty(out_tile_dirty)
  );

  tile_word_t pending_words[$];
  reply_t expected_replies[$];
  tile_word_t cur_word;
  logic [UPDATE_COLUMNS-1:0] tile_map [UPDATE_ROWS];

  int n_words = 0;
  int n_loaded = 0;
  int n_taken = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_cycles = 0;
  int n_marks_taken = 0;
  int n_marks_refused = 0;
  int n_dirty_hits = 0;
  int hold_left = 0;
  int holds_done = 0;

  // idle mix rotates every 128 words: none, sender, receiver, both
  wire [1:0] idle_phase = 2'((n_loaded >> 7) & 3);
  int send_idle_pct;
  int stall_pct;
  assign send_idle_pct = (idle_phase == 2'd1) ? 55 : (idle_phase == 2'd3) ? 33 : 0;
  assign stall_pct = (idle_phase == 2'd2) ? 55 : (idle_phase == 2'd3) ? 33 : 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic reply_t predict_reply(input tile_word_t w);
    reply_t r;
    int xt1, yt1, xt2, yt2;
    r.accepted = 1'b1;
    r.tile_dirty = 1'b0;
    case (w.func)
      FUNC_MARK: begin
        // arithmetic shift gives the floor for negative corners
        xt1 = int'($signed(w.left_x)) >>> TILE_SHIFT;
        yt1 = int'($signed(w.top_y)) >>> TILE_SHIFT;
        xt2 = int'($signed(w.right_x)) >>> TILE_SHIFT;
        yt2 = int'($signed(w.bottom_y)) >>> TILE_SHIFT;
        if (xt1 < 0) xt1 = 0;
        else if (xt1 >= UPDATE_COLUMNS - 1) r.accepted = 1'b0;
        if (yt1 < 0) yt1 = 0;
        else if (yt1 > UPDATE_ROWS) r.accepted = 1'b0;
        if (xt2 < 0) r.accepted = 1'b0;
        else if (xt2 >= UPDATE_COLUMNS - 1) xt2 = UPDATE_COLUMNS - 2;
        if (yt2 < 0) r.accepted = 1'b0;
        else if (yt2 >= UPDATE_ROWS) yt2 = UPDATE_ROWS - 1;
        if (r.accepted) begin
          n_marks_taken++;
          // an empty clipped range is taken with nothing set
          for (int y = yt1; y <= yt2; y++)
            for (int x = xt1; x <= xt2; x++)
              tile_map[y][x] = 1'b1;
        end else begin
          n_marks_refused++;
        end
      end
      FUNC_CLEAR: begin
        for (int y = 0; y < UPDATE_ROWS; y++) tile_map[y] = '0;
      end
      FUNC_QUERY: begin
        r.tile_dirty = tile_map[w.query_row][w.query_col];
        if (r.tile_dirty) n_dirty_hits++;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_word(input logic [1:0] func, input int lx, input int ty,
                          input int rx, input int by, input int qc, input int qr);
    tile_word_t w;
    w.func = func;
    w.left_x = 16'(lx);
    w.top_y = 16'(ty);
    w.right_x = 16'(rx);
    w.bottom_y = 16'(by);
    w.query_col = 5'(qc);
    w.query_row = 4'(qr);
    pending_words.push_back(w);
    n_words++;
  endtask

  // sender: hold a stalled word, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_replies.push_back(predict_reply(cur_word));
        n_taken <= n_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_word = pending_words.pop_front();
          in_valid <= 1'b1;
          in_func <= cur_word.func;
          in_left_x <= cur_word.left_x;
          in_top_y <= cur_word.top_y;
          in_right_x <= cur_word.right_x;
          in_bottom_y <= cur_word.bottom_y;
          in_query_col <= cur_word.query_col;
          in_query_row <= cur_word.query_row;
          n_loaded <= n_loaded + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-offs so the command queue fills and stalls the input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && n_loaded >= 300) ||
                 (holds_done == 1 && n_loaded >= 780)) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      n_checked <= n_checked + 1;
      if (expected_replies.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected reply: accepted %0b tile_dirty %0b",
                   out_accepted, out_tile_dirty);
      end else begin
        exp_r = expected_replies.pop_front();
        if (out_accepted !== exp_r.accepted || out_tile_dirty !== exp_r.tile_dirty) begin
          n_errors++;
          if (n_errors <= 10)
            $display("reply %0d: accepted exp %0b got %0b, tile_dirty exp %0b got %0b",
                     n_checked, exp_r.accepted, out_accepted,
                     exp_r.tile_dirty, out_tile_dirty);
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d words taken",
               n_cycles, n_taken, n_words);
      $display("dirty_tile_rect_marker_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int xs [6] = '{-1, 0, 479, 480, 495, 496};
    int ys [6] = '{-1, 0, 255, 256, 271, 272};
    int lx, ty, rx, by, pick;
    for (int y = 0; y < UPDATE_ROWS; y++) tile_map[y] = '0;

    // directed words
    add_word(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
    add_word(FUNC_QUERY, 0, 0, 0, 0, 0, 0);
    add_word(FUNC_MARK, -32768, -32768, -32768, -32768, 0, 0);
    add_word(FUNC_MARK, 32767, 32767, 32767, 32767, 31, 15);
    add_word(FUNC_MARK, -32768, -32768, 32767, 32767, 0, 0);
    add_word(FUNC_QUERY, 0, 0, 0, 0, 31, 0);
    add_word(FUNC_QUERY, 0, 0, 0, 0, 30, 15);
    add_word(FUNC_QUERY, 0, 0, 0, 0, 0, 0);
    add_word(FUNC_SPARE, -1, -1, -1, -1, 31, 15);
    add_word(FUNC_CLEAR, -1, -1, -1, -1, 31, 15);
    add_word(FUNC_QUERY, 0, 0, 0, 0, 5, 5);
    add_word(FUNC_MARK, 0, 256, 100, 300, 0, 0);
    add_word(FUNC_MARK, 0, 272, 100, 300, 0, 0);
    add_word(FUNC_MARK, 480, 0, 1000, 20, 0, 0);
    add_word(FUNC_QUERY, 0, 0, 0, 0, 30, 1);
    add_word(FUNC_MARK, 496, 0, 1000, 20, 0, 0);
    add_word(FUNC_MARK, 100, 100, 50, 150, 0, 0);
    add_word(FUNC_MARK, 0, 0, 100, -1, 0, 0);
    add_word(FUNC_MARK, 0, 0, -1, 100, 0, 0);
    add_word(FUNC_MARK, 17, 33, 40, 50, 0, 0);
    add_word(FUNC_QUERY, 0, 0, 0, 0, 2, 3);
    add_word(FUNC_QUERY, 0, 0, 0, 0, 3, 3);
    add_word(FUNC_QUERY, 0, 0, 0, 0, 31, 15);

    // random words, mostly marks near the grid and queries
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 9))
          7: begin
            lx = $urandom_range(0, 65535);
            ty = $urandom_range(0, 65535);
            rx = $urandom_range(0, 65535);
            by = $urandom_range(0, 65535);
          end
          8: begin
            lx = xs[$urandom_range(0, 5)];
            ty = ys[$urandom_range(0, 5)];
            rx = lx + $urandom_range(0, 40) - 20;
            by = ty + $urandom_range(0, 40) - 20;
          end
          9: begin
            lx = -$urandom_range(1, 4000);
            ty = -$urandom_range(1, 4000);
            rx = $urandom_range(0, 8000) - 2000;
            by = $urandom_range(0, 8000) - 2000;
          end
          default: begin
            lx = $urandom_range(0, 559) - 48;
            ty = $urandom_range(0, 303) - 32;
            rx = lx + $urandom_range(0, 96) - 8;
            by = ty + $urandom_range(0, 64) - 8;
          end
        endcase
        add_word(FUNC_MARK, lx, ty, rx, by, $urandom_range(0, 31), $urandom_range(0, 15));
      end else if (pick < 88) begin
        add_word(FUNC_QUERY, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 31), $urandom_range(0, 15));
      end else if (pick < 93) begin
        add_word(FUNC_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 31), $urandom_range(0, 15));
      end else begin
        add_word(FUNC_SPARE, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 31), $urandom_range(0, 15));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (n_taken != n_words) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (expected_replies.size() != 0) begin
      n_errors += expected_replies.size();
      $display("%0d replies never arrived", expected_replies.size());
    end
    $display("%0d words checked: %0d marks taken, %0d refused, %0d queries saw a dirty tile",
             n_checked, n_marks_taken, n_marks_refused, n_dirty_hits);
    $display("idle phases rotated every 128 words, %0d long output holds, %0d errors",
             holds_done, n_errors);
    if (n_errors == 0) begin
      $display("dirty_tile_rect_marker_unit: match");
    end else begin
      $display("dirty_tile_rect_marker_unit: mismatch");
    end
    $finish;
  end

endmodule
